// ===== hdl/bts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constant tables for the bilinear texture sampler.
// Holds the sRGB decode table, built at elaboration. Depends on nothing.
package bts_pkg;

  localparam int CHAN_W = 24;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [3:0][CHAN_W-1:0] chan4_t;
  typedef logic [CHAN_W-1:0] rom_t [256];

  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_WRAP_U  = 3'd2;
  localparam logic [2:0] REG_WRAP_V  = 3'd3;
  localparam logic [2:0] REG_FLIP    = 3'd4;
  localparam logic [2:0] REG_FILTER  = 3'd5;
  localparam logic [2:0] REG_CHANNEL = 3'd6;
  localparam logic [2:0] REG_SRGB    = 3'd7;

  localparam logic [1:0] WRAP_CLAMP  = 2'd0;
  localparam logic [1:0] WRAP_REPEAT = 2'd1;
  localparam logic [1:0] WRAP_MIRROR = 2'd2;

  localparam logic [2:0] CH_RED   = 3'd0;
  localparam logic [2:0] CH_GREEN = 3'd1;
  localparam logic [2:0] CH_BLUE  = 3'd2;
  localparam logic [2:0] CH_ALPHA = 3'd3;
  localparam logic [2:0] CH_FULL  = 3'd4;

  // Channel values are fractions of 255 * 65536.
  localparam longint unsigned UNIT_DEN  = 64'd16711680;
  localparam longint unsigned UNIT_HALF = 64'd8355840;
  localparam longint unsigned Q31_ONE   = 64'd2147483648;
  localparam longint unsigned Q31_HALF  = 64'd1073741824;

  function automatic longint unsigned q31_mul(longint unsigned a, longint unsigned b);
    return (a * b + Q31_HALF) >> 31;
  endfunction

  function automatic longint unsigned q31_pow5(longint unsigned s);
    longint unsigned s2;
    s2 = q31_mul(s, s);
    return q31_mul(q31_mul(s2, s2), s);
  endfunction

  // Standard sRGB curve: linear segment below the knee, power 2.4 above it,
  // with the fifth root found by bisection in Q31.
  function automatic rom_t build_srgb_rom();
    rom_t rom;
    longint unsigned cc, n, t, t2, lo, hi, mid, m;
    int c, it;
    for (c = 0; c < 256; c++) begin
      cc = longint'(c);
      if (c <= 10) begin
        rom[c] = CHAN_W'((cc * 64'd6553600 + 64'd646) / 64'd1292);
      end else begin
        n  = 64'd1000 * cc + 64'd14025;
        t  = ((n << 31) + 64'd134512) / 64'd269025;
        t2 = q31_mul(t, t);
        lo = 64'd0;
        hi = Q31_ONE;
        for (it = 0; it < 40; it++) begin
          if (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (q31_pow5(mid) <= t2) lo = mid;
            else hi = mid - 64'd1;
          end
        end
        m = q31_mul(t2, lo);
        rom[c] = CHAN_W'((m * UNIT_DEN + Q31_HALF) >> 31);
      end
    end
    return rom;
  endfunction

  localparam rom_t SRGB_ROM = build_srgb_rom();

  // Expands one stored RGBA8 word into four channel values, with optional
  // sRGB decode of colour and broadcast of a single channel.
  function automatic chan4_t decode_texel(logic [31:0] word, logic srgb, logic [2:0] sel);
    chan4_t v;
    logic [7:0] b;
    chan_t s;
    for (int k = 0; k < 4; k++) begin
      b = word[8*k +: 8];
      v[k] = (k < 3 && srgb) ? SRGB_ROM[b] : {b, 16'h0000};
    end
    if (sel < CH_FULL) begin
      s = v[sel[1:0]];
      v[0] = s;
      v[1] = s;
      v[2] = s;
    end
    return v;
  endfunction

endpackage

// ===== hdl/bilinear_texture_sampler.sv =====
`timescale 1ns / 1ps
// Bilinear texture sampler: eight-stage pipeline with a duplicated texel store.
// Throughput is one transaction per cycle while the output is not stalled; every stage has its own valid bit.
// Reset clears the configuration registers and valid bits; data registers and the texel store are not cleared.
// Depends on bts_pkg.
module bilinear_texture_sampler #(
  parameter int MAX_WIDTH       = 256,
  parameter int MAX_HEIGHT      = 256,
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_BITS        = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [7:0]         write_x,
  input  logic [7:0]         write_y,
  input  logic [7:0]         write_red,
  input  logic [7:0]         write_green,
  input  logic [7:0]         write_blue,
  input  logic [7:0]         write_alpha,
  input  logic signed [23:0] u_coord,
  input  logic signed [23:0] v_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_red,
  output logic [15:0]        out_green,
  output logic [15:0]        out_blue,
  output logic [15:0]        out_alpha
);

  // Pipeline overview:
  //   stage 1  optional v flip and coordinate wrap to [0, 1]
  //   stage 2  scale coordinates by the image size (one multiplier per axis)
  //   stage 3  split into texel index and blend weight, wrap the indices,
  //            form the four store addresses
  //   stage 4  texel store access: writes commit here, four reads registered
  //   stage 5  sRGB decode and channel broadcast
  //   stage 6  horizontal blend of both rows
  //   stage 7  vertical blend
  //   stage 8  conversion to output fractions, held as the output register
  // The store is kept in two copies, one per fetched row, each with two read
  // ports, so any pair of columns and rows can be read in the same cycle.
  // Write transactions leave the pipeline after stage 4.

  localparam int F     = COORD_FRAC_BITS;
  localparam int CW    = ((F > 23) ? F : 23) + 2;
  localparam int WSZ   = $clog2(MAX_WIDTH + 1);
  localparam int HSZ   = $clog2(MAX_HEIGHT + 1);
  localparam int SZW   = (WSZ > HSZ) ? WSZ : HSZ;
  localparam int IXW   = SZW + 2;
  localparam int PW    = F + 1 + SZW;
  localparam int PSW   = PW + 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CV    = bts_pkg::CHAN_W;
  localparam int BW    = CV + F + 2;
  localparam int SCW   = CV + OUT_BITS + 1;
  localparam int YQW   = SCW - 16;
  localparam int SH    = OUT_BITS + 17;
  localparam int RCW   = SH - 7;
  localparam int QPW   = YQW + RCW;

  localparam logic signed [CW-1:0]  ONE_S  = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic [F:0]            ONE_U  = {1'b1, {F{1'b0}}};
  localparam logic signed [PSW-1:0] HALF_S = {{(PSW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [IXW-1:0] IX_ONE = IXW'(1);
  // Reciprocal of 255 with enough guard bits that the quotient is exact.
  localparam logic [RCW-1:0] RECIP = RCW'(((64'd1 << SH) + 64'd254) / 64'd255);

  // Configuration registers.
  logic [8:0] cfg_width, cfg_height;
  logic [1:0] wrap_u, wrap_v;
  logic       flip, bilinear, srgb;
  logic [2:0] chan_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= 9'd256;
      cfg_height <= 9'd256;
      wrap_u     <= bts_pkg::WRAP_REPEAT;
      wrap_v     <= bts_pkg::WRAP_REPEAT;
      flip       <= 1'b0;
      bilinear   <= 1'b1;
      chan_sel   <= bts_pkg::CH_FULL;
      srgb       <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bts_pkg::REG_WIDTH:   cfg_width  <= cfg_data;
        bts_pkg::REG_HEIGHT:  cfg_height <= cfg_data;
        bts_pkg::REG_WRAP_U:  wrap_u     <= cfg_data[1:0];
        bts_pkg::REG_WRAP_V:  wrap_v     <= cfg_data[1:0];
        bts_pkg::REG_FLIP:    flip       <= cfg_data[0];
        bts_pkg::REG_FILTER:  bilinear   <= cfg_data[0];
        bts_pkg::REG_CHANNEL: chan_sel   <= cfg_data[2:0];
        bts_pkg::REG_SRGB:    srgb       <= cfg_data[0];
      endcase
    end
  end

  // Sizes in use: zero acts as one, anything above the store saturates.
  logic [SZW-1:0] size_w, size_h;

  always_comb begin
    if (cfg_width == 9'd0) size_w = SZW'(1);
    else if (int'(cfg_width) > MAX_WIDTH) size_w = SZW'(MAX_WIDTH);
    else size_w = SZW'(cfg_width);
    if (cfg_height == 9'd0) size_h = SZW'(1);
    else if (int'(cfg_height) > MAX_HEIGHT) size_h = SZW'(MAX_HEIGHT);
    else size_h = SZW'(cfg_height);
  end

  // Coordinate wrap into [0, 1]. Mirror folds modulo two.
  function automatic logic [F:0] fold_coord(logic signed [CW-1:0] c, logic [1:0] mode);
    logic [F:0] m;
    m = c[F:0];
    if (mode == bts_pkg::WRAP_CLAMP) begin
      if (c < 0) return '0;
      else if (c > ONE_S) return ONE_U;
      else return c[F:0];
    end else if (mode == bts_pkg::WRAP_REPEAT) begin
      return {1'b0, c[F-1:0]};
    end else begin
      if (m <= ONE_U) return m;
      else return (~m) + 1'b1;
    end
  endfunction

  // Index wrap. Indices only reach one step outside [0, size-1], and there
  // clamp and mirror agree.
  function automatic logic [SZW-1:0] fold_index(logic signed [IXW-1:0] i,
                                                logic [SZW-1:0] size, logic [1:0] mode);
    logic signed [IXW-1:0] sz;
    sz = $signed({2'b00, size});
    if (mode == bts_pkg::WRAP_REPEAT) begin
      if (i < 0) return SZW'(sz - IX_ONE);
      else if (i >= sz) return '0;
      else return SZW'(i);
    end else begin
      if (i < 0) return '0;
      else if (i >= sz) return SZW'(sz - IX_ONE);
      else return SZW'(i);
    end
  endfunction

  function automatic logic [AW-1:0] tex_addr(logic [SZW-1:0] x, logic [SZW-1:0] y);
    return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  function automatic logic [CV-1:0] blend(logic [CV-1:0] a, logic [CV-1:0] b,
                                          logic [F-1:0] t);
    logic [F:0] omt;
    logic [BW-1:0] acc;
    omt = ONE_U - {1'b0, t};
    acc = BW'(a) * BW'(omt) + BW'(b) * BW'(t) + BW'(HALF_S);
    return CV'(acc >> F);
  endfunction

  // Result = round(val * (2^OUT_BITS - 1) / (255 * 65536)); the 65536 part is a
  // shift and the 255 part a reciprocal multiply.
  function automatic logic [15:0] scale_out(logic [CV-1:0] r);
    logic [SCW-1:0] x;
    logic [YQW-1:0] y;
    logic [QPW-1:0] p;
    x = (SCW'(r) << OUT_BITS) - SCW'(r) + SCW'(bts_pkg::UNIT_HALF);
    y = x[SCW-1:16];
    p = QPW'(y) * QPW'(RECIP);
    return 16'(p >> SH);
  endfunction

  // Stage valid bits and advance enables. A stage loads whenever it is empty
  // or the stage after it moves, so bubbles close up under a stall.
  logic v1, v2, v3, v4, v5, v6, v7;
  logic en1, en2, en3, en4, en5, en6, en7, en8;

  assign en8      = !out_valid || out_ready;
  assign en7      = !v7 || en8;
  assign en6      = !v6 || en7;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  logic s1_samp, s2_samp, s3_samp, s4_samp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4 && s4_samp;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
      if (en8) out_valid <= v7;
    end
  end

  // Stage 1: flip and coordinate wrap; write address and range check.
  logic signed [CW-1:0] u_ext, v_ext, v_flip;
  logic [F:0]    s1_u, s1_v;
  logic          s1_wok;
  logic [AW-1:0] s1_waddr;
  logic [31:0]   s1_wdata;

  assign u_ext  = CW'(u_coord);
  assign v_ext  = CW'(v_coord);
  assign v_flip = flip ? (ONE_S - v_ext) : v_ext;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_samp  <= req_type;
      s1_u     <= fold_coord(u_ext, wrap_u);
      s1_v     <= fold_coord(v_flip, wrap_v);
      s1_wok   <= (int'(write_x) < MAX_WIDTH) && (int'(write_y) < MAX_HEIGHT);
      s1_waddr <= AW'(write_y) * AW'(MAX_WIDTH) + AW'(write_x);
      s1_wdata <= {write_alpha, write_blue, write_green, write_red};
    end
  end

  // Stage 2: scale by the image size.
  logic [PW-1:0] s2_pu, s2_pv;
  logic          s2_wok;
  logic [AW-1:0] s2_waddr;
  logic [31:0]   s2_wdata;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_samp  <= s1_samp;
      s2_pu    <= PW'(s1_u) * PW'(size_w);
      s2_pv    <= PW'(s1_v) * PW'(size_h);
      s2_wok   <= s1_wok;
      s2_waddr <= s1_waddr;
      s2_wdata <= s1_wdata;
    end
  end

  // Stage 3: in bilinear mode the sample point sits half a texel in, the
  // integer part picks the first neighbour and the fraction is the weight.
  // Nearest mode uses a zero weight and fetches one texel four times.
  logic signed [PSW-1:0] pu, pv;
  logic signed [IXW-1:0] x0, y0;
  logic [SZW-1:0] xa, xb, ya, yb;

  always_comb begin
    pu = $signed({1'b0, s2_pu}) - (bilinear ? HALF_S : '0);
    pv = $signed({1'b0, s2_pv}) - (bilinear ? HALF_S : '0);
    x0 = $signed(pu[PSW-1:F]);
    y0 = $signed(pv[PSW-1:F]);
    xa = fold_index(x0, size_w, wrap_u);
    ya = fold_index(y0, size_h, wrap_v);
    xb = bilinear ? fold_index(x0 + IX_ONE, size_w, wrap_u) : xa;
    yb = bilinear ? fold_index(y0 + IX_ONE, size_h, wrap_v) : ya;
  end

  logic [AW-1:0] s3_a00, s3_a10, s3_a01, s3_a11;
  logic [F-1:0]  s3_tx, s3_ty;
  logic          s3_wok;
  logic [AW-1:0] s3_waddr;
  logic [31:0]   s3_wdata;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_samp  <= s2_samp;
      s3_a00   <= tex_addr(xa, ya);
      s3_a10   <= tex_addr(xb, ya);
      s3_a01   <= tex_addr(xa, yb);
      s3_a11   <= tex_addr(xb, yb);
      s3_tx    <= bilinear ? pu[F-1:0] : '0;
      s3_ty    <= bilinear ? pv[F-1:0] : '0;
      s3_wok   <= s2_wok;
      s3_waddr <= s2_waddr;
      s3_wdata <= s2_wdata;
    end
  end

  // Stage 4: texel store. Both copies take every in-range write; a write commits as it
  // leaves stage 3, so later samples see it and earlier ones do not.
  logic [31:0] mem_a [DEPTH];
  logic [31:0] mem_b [DEPTH];
  logic [31:0] s4_t00, s4_t10, s4_t01, s4_t11;
  logic [F-1:0] s4_tx, s4_ty;

  always_ff @(posedge clk) begin
    if (en4) begin
      if (v3 && !s3_samp && s3_wok) begin
        mem_a[s3_waddr] <= s3_wdata;
        mem_b[s3_waddr] <= s3_wdata;
      end
      s4_t00 <= mem_a[s3_a00];
      s4_t10 <= mem_a[s3_a10];
      s4_t01 <= mem_b[s3_a01];
      s4_t11 <= mem_b[s3_a11];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_samp <= s3_samp;
      s4_tx   <= s3_tx;
      s4_ty   <= s3_ty;
    end
  end

  // Stage 5: decode.
  bts_pkg::chan4_t s5_c00, s5_c10, s5_c01, s5_c11;
  logic [F-1:0] s5_tx, s5_ty;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_c00 <= bts_pkg::decode_texel(s4_t00, srgb, chan_sel);
      s5_c10 <= bts_pkg::decode_texel(s4_t10, srgb, chan_sel);
      s5_c01 <= bts_pkg::decode_texel(s4_t01, srgb, chan_sel);
      s5_c11 <= bts_pkg::decode_texel(s4_t11, srgb, chan_sel);
      s5_tx  <= s4_tx;
      s5_ty  <= s4_ty;
    end
  end

  // Stage 6: horizontal blend of both rows.
  bts_pkg::chan4_t s6_r0, s6_r1;
  logic [F-1:0] s6_ty;

  always_ff @(posedge clk) begin
    if (en6) begin
      for (int k = 0; k < 4; k++) begin
        s6_r0[k] <= blend(s5_c00[k], s5_c10[k], s5_tx);
        s6_r1[k] <= blend(s5_c01[k], s5_c11[k], s5_tx);
      end
      s6_ty <= s5_ty;
    end
  end

  // Stage 7: vertical blend.
  bts_pkg::chan4_t s7_res;

  always_ff @(posedge clk) begin
    if (en7) begin
      for (int k = 0; k < 4; k++) begin
        s7_res[k] <= blend(s6_r0[k], s6_r1[k], s6_ty);
      end
    end
  end

  // Stage 8: output register.
  always_ff @(posedge clk) begin
    if (en8) begin
      out_red   <= scale_out(s7_res[0]);
      out_green <= scale_out(s7_res[1]);
      out_blue  <= scale_out(s7_res[2]);
      out_alpha <= scale_out(s7_res[3]);
    end
  end

endmodule

// ===== hdl/bts_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the bilinear texture sampler, bound to its top level.
// Depends on bilinear_texture_sampler.
module bts_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_red,
  input logic [15:0] out_green,
  input logic [15:0] out_blue,
  input logic [15:0] out_alpha
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_alpha))
    else $error("result transaction changed while stalled");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled although the output side moves");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (.*);
